### hw/rtl/tfc_pkg.sv
// ----------------------------------------------------------------------------
// tfc_pkg
// Constants and helpers for the telemetry frame checker.
// ----------------------------------------------------------------------------
package tfc_pkg;

    localparam int PosWidth = 10;
    localparam int LenWidth = PosWidth + 1;

    localparam logic [7:0] MagicBytes [4] = '{8'h55, 8'h54, 8'h53, 8'h31};
    localparam logic [7:0] VersionByte    = 8'd1;

    localparam logic [PosWidth-1:0] PosVersion    = 10'd4;
    localparam logic [PosWidth-1:0] PosSampleLast = 10'd12;
    localparam logic [PosWidth-1:0] PosTimeLast   = 10'd20;
    localparam logic [PosWidth-1:0] PosIdLen      = 10'd21;
    localparam logic [PosWidth-1:0] PosIdFirst    = 10'd22;
    localparam logic [PosWidth-1:0] FrameMax      = 10'd512;
    localparam logic [PosWidth-1:0] PosMax        = 10'd1023;

    // field offsets measured from the end of the id
    localparam logic [PosWidth-1:0] OffLon     = 10'd4;
    localparam logic [PosWidth-1:0] OffAlt     = 10'd8;
    localparam logic [PosWidth-1:0] OffSpeed   = 10'd12;
    localparam logic [PosWidth-1:0] OffBatt    = 10'd16;
    localparam logic [PosWidth-1:0] OffReady   = 10'd18;
    localparam logic [PosWidth-1:0] OffLink    = 10'd19;

    localparam logic [7:0] IdMax = 8'd64;

    localparam logic [15:0] BatteryMax = 16'd1000;

    localparam logic [LenWidth-1:0] FrameSize0 = 11'd256;
    localparam logic [LenWidth-1:0] FrameSize1 = 11'd384;
    localparam logic [LenWidth-1:0] FrameSize2 = 11'd512;

    localparam logic [7:0] PadMulSample = 8'd131;
    localparam logic [7:0] PadMulPos    = 8'd17;
    localparam logic [7:0] PadSeed      = 8'h5a;

    localparam logic KindId      = 1'b0;
    localparam logic KindSummary = 1'b1;

    // residue mod 3 of a byte; 4 = 1 mod 3 so bit pairs fold by addition
    function automatic logic [1:0] byte_mod3(input logic [7:0] b);
        logic [3:0] s;
        logic [2:0] t;
        s = 4'(b[1:0]) + 4'(b[3:2]) + 4'(b[5:4]) + 4'(b[7:6]);
        t = 3'(s[1:0]) + 3'(s[3:2]);
        if (t >= 3'd3)
        begin
            t = t - 3'd3;
        end
        if (t >= 3'd3)
        begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

    function automatic logic [1:0] mod3_add(input logic [1:0] a, input logic [1:0] b);
        logic [2:0] s;
        s = 3'(a) + 3'(b);
        if (s >= 3'd3)
        begin
            s = s - 3'd3;
        end
        return s[1:0];
    endfunction

endpackage

### hw/rtl/telemetry_frame_checker.sv
// ----------------------------------------------------------------------------
// telemetry_frame_checker
// Byte-serial check and decode of one telemetry frame, with id pass-through.
//
//   channel  | handshake                  | beat
//   byte     | byte_valid / byte_ready    | data_byte, is_last
//   result   | result_valid / result_ready| kind, id_byte, summary fields
//
// One byte per cycle unless stalled; each is checked in the cycle it is taken.
// A result sits in the output register from the cycle after its byte is taken.
// byte_ready drops only while that register is full and not being taken.
// Reset clears the frame state; the frame state also clears after each last byte.
// Sample id mod 3 is kept as a running residue, so no divider is needed.
// ----------------------------------------------------------------------------
module telemetry_frame_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  logic [7:0]         data_byte,
    input  logic               is_last,
    output logic               result_valid,
    input  logic               result_ready,
    output logic               kind,
    output logic [7:0]         id_byte,
    output logic               frame_valid,
    output logic [63:0]        sample_number,
    output logic [63:0]        source_time,
    output logic signed [31:0] latitude,
    output logic signed [31:0] longitude,
    output logic signed [31:0] altitude,
    output logic signed [31:0] ground_speed,
    output logic [9:0]         battery_level,
    output logic [7:0]         readiness,
    output logic [7:0]         link_level
);
    import tfc_pkg::*;

    logic [PosWidth-1:0] pos_reg, pos_next;
    logic                err_reg, err_next;
    logic [7:0]          idlen_reg, idlen_next;
    logic [1:0]          mod3_reg, mod3_next;
    logic [63:0]         sample_reg, sample_next;
    logic [63:0]         time_reg, time_next;
    logic [31:0]         lat_reg, lat_next;
    logic [31:0]         lon_reg, lon_next;
    logic [31:0]         alt_reg, alt_next;
    logic [31:0]         speed_reg, speed_next;
    logic [15:0]         batt_reg, batt_next;
    logic [7:0]          rdy_reg, rdy_next;
    logic [7:0]          link_reg, link_next;

    logic                valid_reg, valid_next;
    logic                kind_reg;
    logic [7:0]          id_reg;
    logic                fvalid_reg;
    logic [63:0]         osample_reg, otime_reg;
    logic [31:0]         olat_reg, olon_reg, oalt_reg, ospeed_reg;
    logic [9:0]          obatt_reg;
    logic [7:0]          ordy_reg, olink_reg;

    logic                accept;
    logic                is_id;
    logic                emit_id;
    logic [PosWidth-1:0] rel;
    logic [PosWidth-1:0] fo;
    logic [15:0]         pad_prod;
    logic [7:0]          pad;
    logic [LenWidth-1:0] total;
    logic [LenWidth-1:0] want;
    logic                ok;

    assign byte_ready = !valid_reg || result_ready;
    assign accept     = byte_valid && byte_ready;

    assign rel      = pos_reg - PosIdFirst;
    assign fo       = rel - PosWidth'(idlen_reg);
    assign pad_prod = 16'(sample_reg[7:0]) * 16'(PadMulSample);
    assign pad      = pad_prod[7:0] + 8'(pos_reg[7:0] * PadMulPos) + PadSeed;
    assign total    = LenWidth'(pos_reg) + 11'd1;

    // the summary sees the state as updated by the last beat itself
    always_comb
    begin
        case (mod3_next)
            2'd0:    want = FrameSize0;
            2'd1:    want = FrameSize1;
            2'd2:    want = FrameSize2;
            default: want = FrameSize0;
        endcase
    end

    always_comb
    begin
        pos_next    = pos_reg;
        err_next    = err_reg;
        idlen_next  = idlen_reg;
        mod3_next   = mod3_reg;
        sample_next = sample_reg;
        time_next   = time_reg;
        lat_next    = lat_reg;
        lon_next    = lon_reg;
        alt_next    = alt_reg;
        speed_next  = speed_reg;
        batt_next   = batt_reg;
        rdy_next    = rdy_reg;
        link_next   = link_reg;
        is_id       = 1'b0;

        if (pos_reg >= FrameMax)
        begin
            err_next = 1'b1;
        end
        else if (pos_reg < PosVersion)
        begin
            if (data_byte != MagicBytes[pos_reg[1:0]])
            begin
                err_next = 1'b1;
            end
        end
        else if (pos_reg == PosVersion)
        begin
            if (data_byte != VersionByte)
            begin
                err_next = 1'b1;
            end
        end
        else if (pos_reg <= PosSampleLast)
        begin
            sample_next = {sample_reg[55:0], data_byte};
            mod3_next   = mod3_add(mod3_reg, byte_mod3(data_byte));
        end
        else if (pos_reg <= PosTimeLast)
        begin
            time_next = {time_reg[55:0], data_byte};
        end
        else if (pos_reg == PosIdLen)
        begin
            idlen_next = data_byte;
            if (data_byte == 8'd0 || data_byte > IdMax)
            begin
                err_next = 1'b1;
            end
        end
        else if (rel < PosWidth'(idlen_reg))
        begin
            is_id = 1'b1;
        end
        else if (fo < OffLon)
        begin
            lat_next = {lat_reg[23:0], data_byte};
        end
        else if (fo < OffAlt)
        begin
            lon_next = {lon_reg[23:0], data_byte};
        end
        else if (fo < OffSpeed)
        begin
            alt_next = {alt_reg[23:0], data_byte};
        end
        else if (fo < OffBatt)
        begin
            speed_next = {speed_reg[23:0], data_byte};
        end
        else if (fo < OffReady)
        begin
            batt_next = {batt_reg[7:0], data_byte};
        end
        else if (fo == OffReady)
        begin
            rdy_next = data_byte;
        end
        else if (fo == OffLink)
        begin
            link_next = data_byte;
        end
        else if (data_byte != pad)
        begin
            err_next = 1'b1;
        end

        if (pos_reg < PosMax)
        begin
            pos_next = pos_reg + 10'd1;
        end
    end

    assign emit_id = is_id && !err_reg && !is_last;
    assign ok      = !err_next && (total == want) && (batt_next <= BatteryMax);

    always_comb
    begin
        valid_next = valid_reg;
        if (accept && (is_last || emit_id))
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            err_reg    <= 1'b0;
            idlen_reg  <= '0;
            mod3_reg   <= '0;
            sample_reg <= '0;
            time_reg   <= '0;
            lat_reg    <= '0;
            lon_reg    <= '0;
            alt_reg    <= '0;
            speed_reg  <= '0;
            batt_reg   <= '0;
            rdy_reg    <= '0;
            link_reg   <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                if (is_last)
                begin
                    pos_reg    <= '0;
                    err_reg    <= 1'b0;
                    idlen_reg  <= '0;
                    mod3_reg   <= '0;
                    sample_reg <= '0;
                    time_reg   <= '0;
                    lat_reg    <= '0;
                    lon_reg    <= '0;
                    alt_reg    <= '0;
                    speed_reg  <= '0;
                    batt_reg   <= '0;
                    rdy_reg    <= '0;
                    link_reg   <= '0;
                end
                else
                begin
                    pos_reg    <= pos_next;
                    err_reg    <= err_next;
                    idlen_reg  <= idlen_next;
                    mod3_reg   <= mod3_next;
                    sample_reg <= sample_next;
                    time_reg   <= time_next;
                    lat_reg    <= lat_next;
                    lon_reg    <= lon_next;
                    alt_reg    <= alt_next;
                    speed_reg  <= speed_next;
                    batt_reg   <= batt_next;
                    rdy_reg    <= rdy_next;
                    link_reg   <= link_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_last)
        begin
            kind_reg    <= KindSummary;
            id_reg      <= '0;
            fvalid_reg  <= ok;
            osample_reg <= sample_next;
            otime_reg   <= time_next;
            olat_reg    <= lat_next;
            olon_reg    <= lon_next;
            oalt_reg    <= alt_next;
            ospeed_reg  <= speed_next;
            obatt_reg   <= batt_next[9:0];
            ordy_reg    <= rdy_next;
            olink_reg   <= link_next;
        end
        else if (accept && emit_id)
        begin
            kind_reg    <= KindId;
            id_reg      <= data_byte;
            fvalid_reg  <= 1'b0;
            osample_reg <= '0;
            otime_reg   <= '0;
            olat_reg    <= '0;
            olon_reg    <= '0;
            oalt_reg    <= '0;
            ospeed_reg  <= '0;
            obatt_reg   <= '0;
            ordy_reg    <= '0;
            olink_reg   <= '0;
        end
    end

    assign result_valid  = valid_reg;
    assign kind          = kind_reg;
    assign id_byte       = id_reg;
    assign frame_valid   = fvalid_reg;
    assign sample_number = osample_reg;
    assign source_time   = otime_reg;
    assign latitude      = olat_reg;
    assign longitude     = olon_reg;
    assign altitude      = oalt_reg;
    assign ground_speed  = ospeed_reg;
    assign battery_level = obatt_reg;
    assign readiness     = ordy_reg;
    assign link_level    = olink_reg;

`ifndef SYNTHESIS
    a_mod3_range: assert property (@(posedge clk) disable iff (!rst_n)
        mod3_reg != 2'd3)
        else $error("sample residue out of range");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_last |=> pos_reg == '0 && !err_reg && mod3_reg == '0)
        else $error("frame state not cleared after last beat");

    a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_last && pos_reg == PosMax |=> pos_reg == PosMax)
        else $error("byte counter wrapped");

    a_id_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept && emit_id |=> result_valid && kind == KindId && id_byte == $past(data_byte))
        else $error("id beat lost");

    a_id_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KindId |-> !frame_valid && battery_level == '0)
        else $error("id beat carries summary data");
`endif

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for telemetry_frame_checker. Frames go in a beat at a
// time, each beat decoded alongside the block to predict the id pass-through
// beats and the end-of-frame summary, which are then matched against the
// result channel. Directed frames cover field extremes and each rejection but
// over-length; short random frames follow, with idle bursts on both channels.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] FrameMagic [4] = '{8'h55, 8'h54, 8'h53, 8'h31};
    localparam logic [7:0] VersionCode    = 8'd1;
    localparam logic [7:0] IdLenMax       = 8'd64;
    localparam logic [9:0] FrameLimit     = 10'd512;
    localparam logic [9:0] PosCeiling     = 10'd1023;
    localparam logic [15:0] BatteryCeiling = 16'd1000;
    localparam int RandomBytes = 100;
    localparam int HoldCycles  = 150;
    localparam int StallLimit  = 1000;

    typedef logic [7:0] byte_q_t [$];

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } link_beat_t;

    typedef struct {
        logic [63:0] sample_id;
        logic [63:0] stamp;
        logic [7:0]  id_len;
        logic [31:0] lat;
        logic [31:0] lon;
        logic [31:0] alt;
        logic [31:0] speed;
        logic [15:0] battery;
        logic [7:0]  ready_b;
        logic [7:0]  link_b;
        int          total;
    } frame_spec_t;

    typedef struct packed {
        logic [9:0]  pos;
        logic        err;
        logic [7:0]  id_len;
        logic [63:0] sample_id;
        logic [63:0] stamp;
        logic [31:0] lat;
        logic [31:0] lon;
        logic [31:0] alt;
        logic [31:0] speed;
        logic [15:0] battery;
        logic [7:0]  ready_b;
        logic [7:0]  link_b;
    } frame_state_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  id_byte;
        logic        frame_valid;
        logic [63:0] sample_number;
        logic [63:0] source_time;
        logic [31:0] latitude;
        logic [31:0] longitude;
        logic [31:0] altitude;
        logic [31:0] ground_speed;
        logic [9:0]  battery_level;
        logic [7:0]  readiness;
        logic [7:0]  link_level;
    } frame_output_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               byte_valid = 1'b0;
    logic               byte_ready;
    logic [7:0]         data_byte = 8'd0;
    logic               is_last = 1'b0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic               kind;
    logic [7:0]         id_byte;
    logic               frame_valid;
    logic [63:0]        sample_number;
    logic [63:0]        source_time;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic signed [31:0] altitude;
    logic signed [31:0] ground_speed;
    logic [9:0]         battery_level;
    logic [7:0]         readiness;
    logic [7:0]         link_level;

    link_beat_t    link_bytes [$];
    frame_output_t frame_outputs_due [$];
    frame_state_t  decoder = '0;
    frame_output_t oldest_due;
    link_beat_t    next_beat;

    int failures = 0;
    int quiet_cycles = 0;
    int send_gap = 0;
    int take_gap = 0;
    int hold_left = 0;
    int hold_asks = 0;
    int holds_served = 0;
    bit idling_on = 1'b1;

    telemetry_frame_checker uut (.*);

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
    end

    function automatic int frame_size(input logic [63:0] sample_id);
        case (sample_id % 64'd3)
            64'd0:   return 256;
            64'd1:   return 384;
            default: return 512;
        endcase
    endfunction

    function automatic logic [7:0] pad_byte(input logic [63:0] sample_id, input int offset);
        return 8'(sample_id[7:0] * 8'd131 + 8'(offset) * 8'd17 + 8'h5a);
    endfunction

    // one accepted beat through the decoder; queues whatever result it causes
    function automatic void decode_frame_byte(input logic [7:0] b, input logic last);
        frame_output_t r;
        int            rel;
        int            fld;
        logic          id_beat;
        logic [10:0]   total;
        id_beat = 1'b0;
        r = '0;
        if (decoder.pos >= FrameLimit)
            decoder.err = 1'b1;
        else if (decoder.pos < 10'd4)
        begin
            if (b != FrameMagic[decoder.pos[1:0]])
                decoder.err = 1'b1;
        end
        else if (decoder.pos == 10'd4)
        begin
            if (b != VersionCode)
                decoder.err = 1'b1;
        end
        else if (decoder.pos <= 10'd12)
            decoder.sample_id = {decoder.sample_id[55:0], b};
        else if (decoder.pos <= 10'd20)
            decoder.stamp = {decoder.stamp[55:0], b};
        else if (decoder.pos == 10'd21)
        begin
            decoder.id_len = b;
            if (b == 8'd0 || b > IdLenMax)
                decoder.err = 1'b1;
        end
        else
        begin
            rel = int'(decoder.pos) - 22;
            if (rel < int'(decoder.id_len))
                id_beat = 1'b1;
            else
            begin
                fld = rel - int'(decoder.id_len);
                if (fld < 4)
                    decoder.lat = {decoder.lat[23:0], b};
                else if (fld < 8)
                    decoder.lon = {decoder.lon[23:0], b};
                else if (fld < 12)
                    decoder.alt = {decoder.alt[23:0], b};
                else if (fld < 16)
                    decoder.speed = {decoder.speed[23:0], b};
                else if (fld < 18)
                    decoder.battery = {decoder.battery[7:0], b};
                else if (fld == 18)
                    decoder.ready_b = b;
                else if (fld == 19)
                    decoder.link_b = b;
                else if (b != pad_byte(decoder.sample_id, int'(decoder.pos)))
                    decoder.err = 1'b1;
            end
        end
        total = 11'(decoder.pos) + 11'd1;
        if (decoder.pos != PosCeiling)
            decoder.pos = decoder.pos + 10'd1;
        if (last)
        begin
            r.kind          = tfc_pkg::KindSummary;
            r.frame_valid   = !decoder.err && int'(total) == frame_size(decoder.sample_id)
                              && decoder.battery <= BatteryCeiling;
            r.sample_number = decoder.sample_id;
            r.source_time   = decoder.stamp;
            r.latitude      = decoder.lat;
            r.longitude     = decoder.lon;
            r.altitude      = decoder.alt;
            r.ground_speed  = decoder.speed;
            r.battery_level = decoder.battery[9:0];
            r.readiness     = decoder.ready_b;
            r.link_level    = decoder.link_b;
            frame_outputs_due.insert(frame_outputs_due.size(), r);
            decoder = '0;
        end
        else if (id_beat && !decoder.err)
        begin
            r.kind    = tfc_pkg::KindId;
            r.id_byte = b;
            frame_outputs_due.insert(frame_outputs_due.size(), r);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got)
        begin
            failures++;
            $error("%s: expected %0h, actual %0h", name, want, got);
        end
    endfunction

    function automatic frame_spec_t random_spec();
        frame_spec_t s;
        s.sample_id = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 40))
                                                  : {$urandom, $urandom};
        s.stamp   = {$urandom, $urandom};
        s.id_len  = 8'($urandom_range(1, 64));
        s.lat     = $urandom;
        s.lon     = $urandom;
        s.alt     = $urandom;
        s.speed   = $urandom;
        s.battery = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 1000));
        s.ready_b = 8'($urandom);
        s.link_b  = 8'($urandom);
        s.total   = frame_size(s.sample_id);
        return s;
    endfunction

    function automatic byte_q_t build_frame(input frame_spec_t s);
        byte_q_t f;
        int      i;
        f = {};
        for (i = 0; i < 4; i++)
            f.insert(f.size(), FrameMagic[i]);
        f.insert(f.size(), VersionCode);
        for (i = 7; i >= 0; i--)
            f.insert(f.size(), s.sample_id[8*i +: 8]);
        for (i = 7; i >= 0; i--)
            f.insert(f.size(), s.stamp[8*i +: 8]);
        f.insert(f.size(), s.id_len);
        for (i = 0; i < int'(s.id_len); i++)
            f.insert(f.size(), 8'($urandom));
        for (i = 3; i >= 0; i--)
            f.insert(f.size(), s.lat[8*i +: 8]);
        for (i = 3; i >= 0; i--)
            f.insert(f.size(), s.lon[8*i +: 8]);
        for (i = 3; i >= 0; i--)
            f.insert(f.size(), s.alt[8*i +: 8]);
        for (i = 3; i >= 0; i--)
            f.insert(f.size(), s.speed[8*i +: 8]);
        f.insert(f.size(), s.battery[15:8]);
        f.insert(f.size(), s.battery[7:0]);
        f.insert(f.size(), s.ready_b);
        f.insert(f.size(), s.link_b);
        while (f.size() < s.total)
            f.insert(f.size(), pad_byte(s.sample_id, f.size()));
        while (f.size() > s.total)
            void'(f.pop_back());
        return f;
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (link_bytes.size() != 0 || byte_valid || frame_outputs_due.size() != 0);
    endtask

    task automatic send_frame(input byte_q_t f, input bit pause);
        int         i;
        link_beat_t beat;
        for (i = 0; i < f.size(); i++)
        begin
            beat = '{data: f[i], last: (i == f.size() - 1)};
            link_bytes.insert(link_bytes.size(), beat);
        end
        if (pause)
            wait_drained();
    endtask

    // byte channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            data_byte  <= 8'd0;
            is_last    <= 1'b0;
        end
        else
        begin
            if (byte_valid && byte_ready)
                decode_frame_byte(data_byte, is_last);
            if (!byte_valid || byte_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    byte_valid <= 1'b0;
                end
                else if (link_bytes.size() == 0)
                    byte_valid <= 1'b0;
                else if (idling_on && $urandom_range(0, 5) == 0)
                begin
                    send_gap = $urandom_range(0, 4);
                    byte_valid <= 1'b0;
                end
                else
                begin
                    next_beat = link_bytes.pop_front();
                    byte_valid <= 1'b1;
                    data_byte  <= next_beat.data;
                    is_last    <= next_beat.last;
                end
            end
        end
    end

    // result channel back-pressure, with the occasional long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (hold_asks != holds_served)
            begin
                holds_served = hold_asks;
                hold_left = HoldCycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (take_gap > 0)
            begin
                take_gap--;
                result_ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                take_gap = $urandom_range(0, 4);
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (frame_outputs_due.size() == 0)
            begin
                failures++;
                $error("result beat with none outstanding: kind %0b id_byte %0h",
                       kind, id_byte);
            end
            else
            begin
                oldest_due = frame_outputs_due.pop_front();
                compare_field("kind", 64'(oldest_due.kind), 64'(kind));
                compare_field("id_byte", 64'(oldest_due.id_byte), 64'(id_byte));
                compare_field("frame_valid", 64'(oldest_due.frame_valid),
                              64'(frame_valid));
                compare_field("sample_number", oldest_due.sample_number, sample_number);
                compare_field("source_time", oldest_due.source_time, source_time);
                compare_field("latitude", 64'(oldest_due.latitude),
                              64'(latitude[31:0]));
                compare_field("longitude", 64'(oldest_due.longitude),
                              64'(longitude[31:0]));
                compare_field("altitude", 64'(oldest_due.altitude),
                              64'(altitude[31:0]));
                compare_field("ground_speed", 64'(oldest_due.ground_speed),
                              64'(ground_speed[31:0]));
                compare_field("battery_level", 64'(oldest_due.battery_level),
                              64'(battery_level));
                compare_field("readiness", 64'(oldest_due.readiness), 64'(readiness));
                compare_field("link_level", 64'(oldest_due.link_level),
                              64'(link_level));
            end
        end
    end

    // watchdog: cycles with work outstanding but no beat moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && byte_ready) || (result_valid && result_ready)
                || (link_bytes.size() == 0 && !byte_valid && frame_outputs_due.size() == 0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= StallLimit)
            begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        frame_spec_t s;
        byte_q_t     f;
        int          sent;
        int          pick;
        int          idx;
        wait (rst_n);
        @(negedge clk);

        // valid 256-byte frame, longest id, field extremes; receiver holds off
        s = random_spec();
        s.sample_id = 64'd3;
        s.total     = 256;
        s.id_len    = 8'd64;
        s.lat       = 32'h8000_0000;
        s.lon       = 32'h7fff_ffff;
        s.alt       = 32'h0000_0000;
        s.speed     = 32'hffff_ffff;
        s.battery   = BatteryCeiling;
        s.ready_b   = 8'hff;
        s.link_b    = 8'h00;
        hold_asks++;
        send_frame(build_frame(s), 1'b1);

        // valid 384-byte frame, shortest id, opposite extremes
        s.sample_id = 64'hffff_ffff_ffff_fffd;
        s.stamp     = 64'hffff_ffff_ffff_ffff;
        s.total     = 384;
        s.id_len    = 8'd1;
        s.lat       = 32'h7fff_ffff;
        s.lon       = 32'h8000_0000;
        s.alt       = 32'hffff_ffff;
        s.speed     = 32'h0000_0000;
        s.battery   = 16'd0;
        s.ready_b   = 8'h00;
        s.link_b    = 8'hff;
        send_frame(build_frame(s), 1'b1);

        // battery out of range; the low ten bits are still reported
        s = random_spec();
        s.sample_id = 64'd9;
        s.total     = 256;
        s.battery   = 16'h0401;
        send_frame(build_frame(s), 1'b1);

        // bad id lengths, cut short just after the id starts
        s = random_spec();
        s.id_len = 8'd0;
        f = build_frame(s);
        send_frame(f[0:27], 1'b1);
        s.id_len = 8'd65;
        f = build_frame(s);
        send_frame(f[0:27], 1'b1);
        s.id_len = 8'd255;
        f = build_frame(s);
        send_frame(f[0:27], 1'b1);

        // bad magic, bad version: id beats must be withheld
        s = random_spec();
        f = build_frame(s);
        f[2] = 8'h00;
        send_frame(f[0:25], 1'b1);
        f = build_frame(s);
        f[4] = 8'h02;
        send_frame(f[0:25], 1'b1);

        // short frames: one beat, ending in the header, ending on an id beat
        s = random_spec();
        f = build_frame(s);
        send_frame(f[0:0], 1'b1);
        send_frame(f[0:10], 1'b1);
        s.id_len = 8'd40;
        f = build_frame(s);
        send_frame(f[0:31], 1'b1);

        // short random frames, cut, corrupted or plain noise
        sent = 0;
        while (sent < RandomBytes)
        begin
            idling_on = ($urandom_range(0, 4) != 0);
            pick = $urandom_range(0, 2);
            s = random_spec();
            f = build_frame(s);
            idx = $urandom_range(1, 40);
            while (f.size() > idx)
                void'(f.pop_back());
            if (pick == 1)
            begin
                idx = $urandom_range(0, f.size() - 1);
                f[idx] ^= 8'($urandom_range(1, 255));
            end
            else if (pick == 2)
            begin
                f = {};
                repeat ($urandom_range(1, 40))
                    f.insert(f.size(), 8'($urandom));
            end
            sent += f.size();
            send_frame(f, $urandom_range(0, 3) == 0);
        end

        // closing stretch, no idling: bad final padding, then a cut frame
        idling_on = 1'b0;
        s = random_spec();
        s.sample_id = 64'd6;
        s.total     = 256;
        s.battery   = 16'd500;
        f = build_frame(s);
        f[f.size() - 1] ^= 8'h01;
        send_frame(f, 1'b0);
        send_frame(f[0:23], 1'b0);
        wait_drained();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/tfc_pkg.sv
hw/rtl/telemetry_frame_checker.sv
dv/testbench.sv
